// ===== sv/usb_pd_contract_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the USB PD contract decoder
// Immediate-implication and next-cycle checks, gated by the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef USB_PD_CONTRACT_DECODER_MACROS_SVH
`define USB_PD_CONTRACT_DECODER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define UPCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define UPCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/upcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upcd_pkg
// Types and constants shared by the USB PD contract decoder modules.
// ----------------------------------------------------------------------------
package upcd_pkg;

  localparam logic [15:0] DEFAULT_MV  = 16'd5000;
  localparam logic [3:0]  CNT_MAX     = 4'd15;
  localparam logic [3:0]  LIMIT_RESET = 4'd5;

  typedef enum logic [1:0] {
    SUPPLY_FIXED    = 2'd0,
    SUPPLY_VARIABLE = 2'd1,
    SUPPLY_BATTERY  = 2'd2,
    SUPPLY_PPS      = 2'd3
  } supply_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FAIL = 1'b1
  } status_t;

  // Decoded contract: what gets cached after a good power object read.
  typedef struct packed {
    logic        contract_active;
    supply_t     pwr_type;
    logic [15:0] bus_mv;
    logic [13:0] bus_ma;
    logic [2:0]  obj_pos;
    logic        cap_mismatch;
  } contract_t;

  typedef struct packed {
    status_t     status_code;
    contract_t   contract;
    logic        from_cache;
    logic [3:0]  failure_count;
  } result_t;

endpackage

// ===== sv/upcd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upcd channel interfaces
// Valid/ready channels for poll items, result items and the limit register.
// ----------------------------------------------------------------------------
interface upcd_in_if;
  logic        valid;
  logic        ready;
  logic        pdo_read_ok;
  logic [31:0] pdo_word;
  logic        rdo_read_ok;
  logic [31:0] rdo_word;

  modport source (output valid, pdo_read_ok, pdo_word, rdo_read_ok, rdo_word,
                  input ready);
  modport sink   (input valid, pdo_read_ok, pdo_word, rdo_read_ok, rdo_word,
                  output ready);
endinterface

interface upcd_out_if;
  logic        valid;
  logic        ready;
  logic        status_code;
  logic        contract_active;
  logic [1:0]  pwr_type;
  logic [15:0] bus_mv;
  logic [13:0] bus_ma;
  logic [2:0]  obj_pos;
  logic        cap_mismatch;
  logic        from_cache;
  logic [3:0]  failure_count;

  modport source (output valid, status_code, contract_active, pwr_type, bus_mv,
                  bus_ma, obj_pos, cap_mismatch, from_cache,
                  failure_count,
                  input ready);
  modport sink   (input valid, status_code, contract_active, pwr_type, bus_mv,
                  bus_ma, obj_pos, cap_mismatch, from_cache,
                  failure_count,
                  output ready);
endinterface

interface upcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] error_limit;

  modport source (output valid, error_limit, input ready);
  modport sink   (input valid, error_limit, output ready);
endinterface

// ===== sv/upcd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upcd_decode
// Decodes a power data object and request data object into a contract.
// ----------------------------------------------------------------------------
module upcd_decode
  import upcd_pkg::*;
(
  input  logic [31:0] pdo_word,
  input  logic        rdo_read_ok,
  input  logic [31:0] rdo_word,
  output contract_t   contract
);

  supply_t     sup;
  logic [15:0] pdo_mv;
  logic [13:0] pdo_ma;
  logic [13:0] rdo_ma;
  logic        rdo_use;

  assign sup = supply_t'(pdo_word[31:30]);
  assign rdo_ma  = {4'd0, rdo_word[19:10]} * 14'd10;
  assign rdo_use = rdo_read_ok && (rdo_word != 32'd0);

  always_comb begin
    case (sup)
      SUPPLY_FIXED: begin
        pdo_mv = {6'd0, pdo_word[19:10]} * 16'd50;
        pdo_ma = {4'd0, pdo_word[9:0]} * 14'd10;
      end
      SUPPLY_PPS: begin
        pdo_mv = {8'd0, pdo_word[24:17]} * 16'd100;
        pdo_ma = {7'd0, pdo_word[6:0]} * 14'd50;
      end
      default: begin
        // variable and battery share the layout; battery current read as written
        pdo_mv = {6'd0, pdo_word[29:20]} * 16'd50;
        pdo_ma = {4'd0, pdo_word[9:0]} * 14'd10;
      end
    endcase
  end

  always_comb begin
    contract = '{contract_active: 1'b0,
                 pwr_type:        SUPPLY_FIXED,
                 bus_mv:          DEFAULT_MV,
                 bus_ma:          14'd0,
                 obj_pos:         3'd0,
                 cap_mismatch:    1'b0};
    if (pdo_word != 32'd0) begin
      contract.contract_active = 1'b1;
      contract.pwr_type        = sup;
      contract.bus_mv          = pdo_mv;
      contract.bus_ma          = pdo_ma;
      if (rdo_use) begin
        contract.obj_pos      = rdo_word[30:28];
        contract.cap_mismatch = rdo_word[26];
        // a zero request current leaves the offered current in place
        if (rdo_word[19:10] != 10'd0) begin
          contract.bus_ma = rdo_ma;
        end
      end
    end
  end

endmodule

// ===== sv/usb_pd_contract_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_pd_contract_decoder
// Decodes polled PD contract words, tracks read failures, serves a cache.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per poll (power object word and request object word,
//            each with a read-ok bit). Taken when valid and ready are high.
//   out_ch : one result item per poll item, in order.
//   cfg_ch : writes error_limit; always ready, write only while idle.
// Path: an accepted item goes into the input register, then is decoded, with
//   the state update, into the result register, from which out_ch takes it.
// Throughput: one item per cycle while out_ch is ready; the failure counter
//   and the cache update in the same cycle as the decode, so each item sees
//   the one before it. Reset: failure counter cleared, no cache,
//   error_limit back to 5, both stages empty.
// Stall: when out_ch.ready is low the result holds; one more item still
//   enters the input register if it is empty, after which in_ch.ready drops.
// ----------------------------------------------------------------------------
`include "usb_pd_contract_decoder_macros.svh"

module usb_pd_contract_decoder
  import upcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  upcd_in_if.sink    in_ch,
  upcd_out_if.source out_ch,
  upcd_cfg_if.sink   cfg_ch
);

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_pdo_ok_r;
  logic [31:0] s1_pdo_r;
  logic        s1_rdo_ok_r;
  logic [31:0] s1_rdo_r;

  // tracking state
  logic [3:0]  limit_r;
  logic [3:0]  fail_cnt_r, fail_cnt_nxt;
  logic        cache_ok_r;
  contract_t   cache_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  logic        in_fire;
  logic        out_adv;
  logic        s1_fire;
  logic [3:0]  fail_inc;
  contract_t   dec;

  assign out_adv  = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  upcd_decode u_decode (
    .pdo_word    (s1_pdo_r),
    .rdo_read_ok (s1_rdo_ok_r),
    .rdo_word    (s1_rdo_r),
    .contract    (dec)
  );

  assign fail_inc = (fail_cnt_r != CNT_MAX) ? fail_cnt_r + 4'd1 : fail_cnt_r;

  always_comb begin
    fail_cnt_nxt = fail_cnt_r;
    res_nxt      = res_r;
    if (s1_fire) begin
      if (s1_pdo_ok_r) begin
        fail_cnt_nxt = 4'd0;
        res_nxt = '{status_code: STATUS_OK, contract: dec, from_cache: 1'b0,
                    failure_count: 4'd0};
      end else begin
        fail_cnt_nxt = fail_inc;
        if (cache_ok_r && (fail_inc < limit_r)) begin
          res_nxt = '{status_code: STATUS_OK, contract: cache_r, from_cache: 1'b1,
                      failure_count: fail_inc};
        end else begin
          res_nxt = '{status_code: STATUS_FAIL,
                      contract: '{contract_active: 1'b0,
                                  pwr_type:        SUPPLY_FIXED,
                                  bus_mv:          DEFAULT_MV,
                                  bus_ma:          14'd0,
                                  obj_pos:         3'd0,
                                  cap_mismatch:    1'b0},
                      from_cache: 1'b0,
                      failure_count: fail_inc};
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fail_cnt_r  <= 4'd0;
      cache_ok_r  <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
      if (s1_fire && s1_pdo_ok_r) begin
        cache_ok_r <= 1'b1;
      end
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.error_limit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pdo_ok_r <= in_ch.pdo_read_ok;
      s1_pdo_r    <= in_ch.pdo_word;
      s1_rdo_ok_r <= in_ch.rdo_read_ok;
      s1_rdo_r    <= in_ch.rdo_word;
    end
    if (s1_fire && s1_pdo_ok_r) begin
      cache_r <= dec;
    end
    res_r <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status_code     = res_r.status_code;
  assign out_ch.contract_active = res_r.contract.contract_active;
  assign out_ch.pwr_type        = res_r.contract.pwr_type;
  assign out_ch.bus_mv          = res_r.contract.bus_mv;
  assign out_ch.bus_ma          = res_r.contract.bus_ma;
  assign out_ch.obj_pos         = res_r.contract.obj_pos;
  assign out_ch.cap_mismatch    = res_r.contract.cap_mismatch;
  assign out_ch.from_cache      = res_r.from_cache;
  assign out_ch.failure_count   = res_r.failure_count;

  `UPCD_ASSERT_NOW(a_fail_default, clk, rst_n,
    out_valid_r && (res_r.status_code == STATUS_FAIL),
    !res_r.from_cache && !res_r.contract.contract_active &&
    (res_r.contract.bus_mv == DEFAULT_MV), "failure result is not the default status")
  `UPCD_ASSERT_NEXT(a_good_clears, clk, rst_n, s1_fire && s1_pdo_ok_r,
    (fail_cnt_r == 4'd0) && cache_ok_r, "good read did not clear counter or fill cache")
  `UPCD_ASSERT_NEXT(a_fail_counts, clk, rst_n,
    s1_fire && !s1_pdo_ok_r && (fail_cnt_r != CNT_MAX),
    fail_cnt_r == $past(fail_cnt_r) + 4'd1, "failed read did not advance counter")
  `UPCD_ASSERT_NOW(a_cache_served, clk, rst_n, out_valid_r && res_r.from_cache,
    cache_ok_r && (res_r.failure_count < limit_r), "cache served without cache or past limit")
  `UPCD_ASSERT_NEXT(a_hold_stage, clk, rst_n, s1_valid_r && !out_adv,
    s1_valid_r, "input stage dropped a held item")

endmodule

// ===== bench/tb_usb_pd_contract_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_pd_contract_decoder
// Drives poll items into the PD contract decoder under random valid/ready
// gaps, except in one phase, and checks every result item in order against
// an in-bench model of the decode, the failure counter and the status cache.
// The error limit is rewritten between phases, including the top of its range.
// ----------------------------------------------------------------------------
module tb_usb_pd_contract_decoder;
  import upcd_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AT     = 120;

  class contract_checker;
    logic [3:0] limit;
    logic [3:0] fails;
    bit         have_cache;
    contract_t  cache;
    result_t    status_q[$];
    int         errors;

    function new();
      limit      = LIMIT_RESET;
      fails      = '0;
      have_cache = 1'b0;
      cache      = '0;
      cache.bus_mv = DEFAULT_MV;
      errors     = 0;
    endfunction

    function void note_limit(logic [3:0] value);
      limit = value;
    endfunction

    function int outstanding();
      return status_q.size();
    endfunction

    function void note_poll(bit pdo_ok, logic [31:0] pdo, bit rdo_ok, logic [31:0] rdo);
      result_t   r;
      contract_t c;
      r = '0;
      c = '0;
      c.pwr_type    = SUPPLY_FIXED;
      c.bus_mv      = DEFAULT_MV;
      r.status_code = STATUS_OK;
      if (!pdo_ok) begin
        if (fails != CNT_MAX) fails++;
        if (fails >= limit || !have_cache) begin
          r.status_code = STATUS_FAIL;
          r.contract    = c;
        end else begin
          r.contract   = cache;
          r.from_cache = 1'b1;
        end
      end else begin
        fails = '0;
        if (pdo != '0) begin
          c.contract_active = 1'b1;
          c.pwr_type        = supply_t'(pdo[31:30]);
          case (c.pwr_type)
            SUPPLY_FIXED: begin
              c.bus_mv = pdo[19:10] * 16'd50;
              c.bus_ma = pdo[9:0] * 14'd10;
            end
            SUPPLY_PPS: begin
              c.bus_mv = pdo[24:17] * 16'd100;
              c.bus_ma = pdo[6:0] * 14'd50;
            end
            default: begin
              // battery current field is taken as written, same as variable
              c.bus_mv = pdo[29:20] * 16'd50;
              c.bus_ma = pdo[9:0] * 14'd10;
            end
          endcase
          if (rdo_ok && rdo != '0) begin
            c.obj_pos      = rdo[30:28];
            c.cap_mismatch = rdo[26];
            if (rdo[19:10] != '0) c.bus_ma = rdo[19:10] * 14'd10;
          end
        end
        cache      = c;
        have_cache = 1'b1;
        r.contract = c;
      end
      r.failure_count = fails;
      status_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (status_q.size() == 0) begin
        $display("%0t: result with no poll outstanding, got %h", $time, got);
        errors++;
        return;
      end
      want = status_q.pop_front();
      compare_field("status_code", 32'(want.status_code), 32'(got.status_code));
      compare_field("contract_active", 32'(want.contract.contract_active),
                    32'(got.contract.contract_active));
      compare_field("pwr_type", 32'(want.contract.pwr_type), 32'(got.contract.pwr_type));
      compare_field("bus_mv", 32'(want.contract.bus_mv), 32'(got.contract.bus_mv));
      compare_field("bus_ma", 32'(want.contract.bus_ma), 32'(got.contract.bus_ma));
      compare_field("obj_pos", 32'(want.contract.obj_pos), 32'(got.contract.obj_pos));
      compare_field("cap_mismatch", 32'(want.contract.cap_mismatch),
                    32'(got.contract.cap_mismatch));
      compare_field("from_cache", 32'(want.from_cache), 32'(got.from_cache));
      compare_field("failure_count", 32'(want.failure_count), 32'(got.failure_count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b1;
  int   results_seen = 0;
  int   stuck_cycles = 0;
  contract_checker board = new();

  upcd_in_if  in_ch();
  upcd_out_if out_ch();
  upcd_cfg_if cfg_ch();

  usb_pd_contract_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  task automatic send_poll(bit pdo_ok, logic [31:0] pdo, bit rdo_ok, logic [31:0] rdo);
    while (idle_on && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pdo_read_ok <= pdo_ok;
    in_ch.pdo_word    <= pdo;
    in_ch.rdo_read_ok <= rdo_ok;
    in_ch.rdo_word    <= rdo;
    do @(posedge clk); while (!in_ch.ready);
    board.note_poll(pdo_ok, pdo, rdo_ok, rdo);
  endtask

  task automatic send_random_polls(int count);
    int          burst;
    bit          pdo_ok;
    bit          rdo_ok;
    logic [31:0] pdo;
    logic [31:0] rdo;
    burst = 0;
    repeat (count) begin
      // failure bursts of up to 18 polls, long enough to pass any limit and saturate the counter
      if (burst == 0 && $urandom_range(99) < 6) burst = $urandom_range(18, 1);
      if (burst > 0) begin
        pdo_ok = 1'b0;
        burst--;
      end else begin
        pdo_ok = ($urandom_range(99) >= 8);
      end
      pdo    = ($urandom_range(9) == 0) ? 32'h0 : 32'($urandom);
      rdo_ok = ($urandom_range(99) < 80);
      case ($urandom_range(9))
        0:       rdo = 32'h0;
        1, 2:    rdo = $urandom & ~32'h000F_FC00;
        default: rdo = $urandom;
      endcase
      send_poll(pdo_ok, pdo, rdo_ok, rdo);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [3:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.error_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    board.note_limit(value);
  endtask

  initial begin
    int limits [5] = '{15, 1, 3, 9, 5};
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.pdo_read_ok  <= 1'b0;
    in_ch.pdo_word     <= '0;
    in_ch.rdo_read_ok  <= 1'b0;
    in_ch.rdo_word     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.error_limit <= LIMIT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed polls under the reset limit
    send_poll(1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);  // fail before any cache
    send_poll(1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);  // zero object, request ignored
    send_poll(1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000);  // served from cache
    send_poll(1'b1, 32'h000F_FFFF, 1'b0, 32'hFFFF_FFFF);  // fixed, request not read
    send_poll(1'b1, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF);  // variable, full request
    send_poll(1'b1, 32'hBFF0_03FF, 1'b1, 32'h0000_0000);  // battery, zero request
    send_poll(1'b1, 32'hFFFF_FFFF, 1'b1, 32'h7400_0000);  // PPS max, zero request current
    send_poll(1'b1, 32'hC000_0000, 1'b1, 32'h0000_0400);  // PPS min, request current wins
    send_poll(1'b1, 32'h0000_0001, 1'b1, 32'h8000_0000);  // fixed min
    send_poll(1'b1, 32'h4000_0000, 1'b0, 32'h1234_5678);  // variable, zero fields
    repeat (7) send_poll(1'b0, $urandom, 1'b1, $urandom);  // cross the limit
    send_poll(1'b1, 32'h0001_912C, 1'b1, 32'h1004_B000);

    foreach (limits[i]) begin
      drain();
      write_limit(4'(limits[i]));
      idle_on = (i != 2);
      send_random_polls(110);
    end
    idle_on = 1'b1;
    drain();

    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int      hold_left;
    bit      held_once;
    result_t got;
    hold_left = 0;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status_code              = status_t'(out_ch.status_code);
        got.contract.contract_active = out_ch.contract_active;
        got.contract.pwr_type        = supply_t'(out_ch.pwr_type);
        got.contract.bus_mv          = out_ch.bus_mv;
        got.contract.bus_ma          = out_ch.bus_ma;
        got.contract.obj_pos         = out_ch.obj_pos;
        got.contract.cap_mismatch    = out_ch.cap_mismatch;
        got.from_cache               = out_ch.from_cache;
        got.failure_count            = out_ch.failure_count;
        board.check_result(got);
        results_seen++;
      end
      // hold off once so the block backs up into its input
      if (!held_once && results_seen == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 19);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
